// ----- rtl/assert_macros.svh -----
// Assertion helper macros used by the top level of the fraction approximator.
// No dependencies; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RFA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/rfa_pkg.sv -----
// Shared types and constants of the rational fraction approximator.
// No dependencies; used by the divider and the top level.
`default_nettype none
package rfa_pkg;

    localparam int FRAC_BITS = 16;
    localparam int VAL_W     = 31;
    localparam int DIV_W     = 97;
    localparam int WIDE_W    = 98;
    localparam int KQ_W      = 33;
    localparam int CNT_W     = 7;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_ZERO = 2'd1;
    localparam logic [1:0] STAT_CAP  = 2'd2;
    localparam logic [1:0] STAT_OVF  = 2'd3;

    typedef struct packed {
        logic            done;
        logic [KQ_W-1:0] quo;
        logic            big;
        logic            rem_zero;
    } t_div_res;

    typedef enum logic [4:0] {
        S_IDLE, S_SDIV, S_SDIVW, S_MX, S_MT, S_CHK,
        S_U0, S_U1, S_U2, S_U3, S_U4, S_V1, S_V2, S_V3, S_V4,
        S_DSET, S_DIVW, S_K, S_J0, S_J1, S_J2, S_J3, S_J4, S_OUT
    } t_state;

endpackage
`default_nettype wire

// ----- rtl/rfa_mul.sv -----
// Shared 32x32 unsigned multiplier with a registered product.
// No dependencies.
`default_nettype none
module rfa_mul (
    input  wire logic        i_clk,
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    output logic      [63:0] o_prod
);
    logic [63:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(i_a) * 64'(i_b);
    end

    assign o_prod = r_prod;
endmodule
`default_nettype wire

// ----- rtl/rfa_div.sv -----
// Restoring bit-serial divider, one quotient bit per cycle.
// Depends on rfa_pkg; the quotient keeps KQ_W low bits plus a sticky overflow.
`default_nettype none
module rfa_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [rfa_pkg::DIV_W-1:0]   i_dividend,
    input  wire logic [rfa_pkg::DIV_W-1:0]   i_divisor,
    output rfa_pkg::t_div_res                o_res
);
    import rfa_pkg::*;

    logic              r_busy, r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIV_W-1:0]  r_num, r_den, r_rem;
    logic [KQ_W-1:0]   r_quo;
    logic              r_big;
    logic [DIV_W:0]    rem_sh;
    logic [DIV_W+1:0]  diff;
    logic              ge;

    always_comb begin
        rem_sh = {r_rem, r_num[DIV_W-1]};
        diff   = {1'b0, rem_sh} - {2'b0, r_den};
        ge     = !diff[DIV_W+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_W-1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_den <= i_divisor;
            r_rem <= '0;
            r_quo <= '0;
            r_big <= 1'b0;
        end else if (r_busy) begin
            r_num <= {r_num[DIV_W-2:0], 1'b0};
            r_rem <= ge ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
            r_quo <= {r_quo[KQ_W-2:0], ge};
            r_big <= r_big | r_quo[KQ_W-1];
        end
    end

    assign o_res.done     = r_done;
    assign o_res.quo      = r_quo;
    assign o_res.big      = r_big;
    assign o_res.rem_zero = (r_rem == '0);
endmodule
`default_nettype wire

// ----- rtl/rational_fraction_approximator_unit.sv -----
// Finds num/den within the tolerance of an unsigned Q16.16 value by an accelerated
// Stern-Brocot mediant search, one word at a time. The bit-serial divider forms the
// jump count of a search step, and a word takes up to MAX_STEPS steps.
// Depends on rfa_pkg, rfa_mul, rfa_div.
`default_nettype none
`include "assert_macros.svh"
module rational_fraction_approximator_unit #(
    parameter int MAX_STEPS = 1000
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [31:0] i_x_value,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [30:0]      o_numerator,
    output logic [30:0]      o_denominator,
    output logic [1:0]       o_status,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [31:0] i_cfg_data
);
    import rfa_pkg::*;

    localparam int SW = $clog2(MAX_STEPS + 1);

    t_state r_state, n_state;

    logic [31:0]       r_tol, r_x;
    logic [VAL_W-1:0]  r_ln, r_ld, r_rn, r_rd, r_p, r_q;
    logic [1:0]        r_stat;
    logic [SW-1:0]     r_steps;
    logic [63:0]       r_xq, r_e;
    logic              r_eneg, r_below;
    logic [WIDE_W-1:0] r_te, r_ts, r_u, r_v;
    logic              r_kdiff, r_kneg;
    logic [KQ_W-1:0]   r_kmag;
    logic [64:0]       r_j;
    logic [66:0]       r_n1, r_n2;
    logic              r_o_valid;
    logic [VAL_W-1:0]  r_o_num, r_o_den;
    logic [1:0]        r_o_stat;

    logic [31:0]       mul_a, mul_b;
    logic [63:0]       prod;
    logic              div_start;
    logic [DIV_W-1:0]  div_num, div_den;
    t_div_res          div_res;
    logic              in_acc, out_load;

    // Per-state datapath terms.
    logic [63:0]       ps;
    logic              below, above;
    logic [65:0]       ediff;
    logic [WIDE_W-1:0] dnum, dden;
    logic [KQ_W-1:0]   kcap;
    logic [VAL_W-1:0]  a1, a2, base1, base2;
    logic [64:0]       jhi1, jhi2;
    logic [VAL_W-1:0]  nln, nld, nrn, nrd;
    logic [31:0]       np, nq;
    logic              ok_jump;

    rfa_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    rfa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_num),
        .i_divisor  (div_den),
        .o_res      (div_res)
    );

    always_comb begin
        ps    = 64'(r_p) << FRAC_BITS;
        below = (65'(ps) + 65'(prod)) < 65'(r_xq);
        above = 65'(ps) > (65'(r_xq) + 65'(prod));
        ediff = {1'b0, r_xq, 1'b0} - 66'(ps);
        dnum  = r_below ? r_v : r_u;
        dden  = r_below ? r_u : r_v;
        kcap  = (div_res.big || (div_res.quo[KQ_W-1] && (div_res.quo[KQ_W-2:0] != '0)))
              ? {1'b1, {(KQ_W-1){1'b0}}} : div_res.quo;
        a1    = r_below ? r_ln : r_rn;
        a2    = r_below ? r_ld : r_rd;
        base1 = r_below ? r_rn : r_ln;
        base2 = r_below ? r_rd : r_ld;
        jhi1  = r_kmag[KQ_W-1] ? {2'b0, a1, 32'b0} : '0;
        jhi2  = r_kmag[KQ_W-1] ? {2'b0, a2, 32'b0} : '0;
        nln   = r_below ? r_ln : r_n1[VAL_W-1:0];
        nld   = r_below ? r_ld : r_n2[VAL_W-1:0];
        nrn   = r_below ? r_n1[VAL_W-1:0] : r_rn;
        nrd   = r_below ? r_n2[VAL_W-1:0] : r_rd;
        np    = 32'(nln) + 32'(nrn);
        nq    = 32'(nld) + 32'(nrd);
        ok_jump = (r_n1[66:VAL_W] == '0) && (r_n2[66:VAL_W] == '0)
                && !np[31] && !nq[31];
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_x_value == '0)      n_state = S_OUT;
                    else if (i_x_value <= r_tol) n_state = S_SDIV;
                    else                      n_state = S_MX;
                end
            end
            S_SDIV:  n_state = S_SDIVW;
            S_SDIVW: if (div_res.done) n_state = S_OUT;
            S_MX:    n_state = S_MT;
            S_MT:    n_state = S_CHK;
            S_CHK: begin
                if ((!below && !above) || (r_steps >= SW'(MAX_STEPS))) n_state = S_OUT;
                else n_state = S_U0;
            end
            S_U0:    n_state = S_U1;
            S_U1:    n_state = S_U2;
            S_U2:    n_state = S_U3;
            S_U3:    n_state = S_U4;
            S_U4:    n_state = S_V1;
            S_V1:    n_state = S_V2;
            S_V2:    n_state = S_V3;
            S_V3:    n_state = S_V4;
            S_V4:    n_state = S_DSET;
            S_DSET:  n_state = (dden == '0) ? S_J0 : S_DIVW;
            S_DIVW:  if (div_res.done) n_state = S_K;
            S_K:     n_state = S_J0;
            S_J0:    n_state = S_J1;
            S_J1:    n_state = S_J2;
            S_J2:    n_state = S_J3;
            S_J3:    n_state = S_J4;
            S_J4:    n_state = ok_jump ? S_MX : S_OUT;
            S_OUT:   if (!r_o_valid || !i_out_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        out_load  = 1'b0;
        unique case (r_state)
            S_SDIV: begin
                div_start = 1'b1;
                div_num   = DIV_W'(1) << FRAC_BITS;
                div_den   = DIV_W'(r_tol);
            end
            S_MX: begin mul_a = r_x;             mul_b = 32'(r_q); end
            S_MT: begin mul_a = r_tol;           mul_b = 32'(r_q); end
            S_U0: begin mul_a = 32'(r_ld);       mul_b = r_e[31:0]; end
            S_U1: begin mul_a = 32'(r_ld);       mul_b = r_e[63:32]; end
            S_U2: begin mul_a = 32'(r_ln);       mul_b = 32'(r_q); end
            S_U4: begin mul_a = 32'(r_rd);       mul_b = r_e[31:0]; end
            S_V1: begin mul_a = 32'(r_rd);       mul_b = r_e[63:32]; end
            S_V2: begin mul_a = 32'(r_rn);       mul_b = 32'(r_q); end
            S_DSET: begin
                div_start = (dden != '0);
                div_num   = dnum[WIDE_W-1] ? DIV_W'(-dnum) : dnum[DIV_W-1:0];
                div_den   = dden[WIDE_W-1] ? DIV_W'(-dden) : dden[DIV_W-1:0];
            end
            S_J0: begin mul_a = r_kmag[31:0];    mul_b = 32'(a1); end
            S_J1: begin mul_a = r_kmag[31:0];    mul_b = 32'(a2); end
            S_OUT: out_load = !r_o_valid || !i_out_stall;
            default: ;
        endcase
    end

    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_tol     <= 32'd655;
            r_o_valid <= 1'b0;
            r_steps   <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) r_tol <= i_cfg_data;
            if (out_load)         r_o_valid <= 1'b1;
            else if (!i_out_stall) r_o_valid <= 1'b0;
            if (r_state == S_IDLE) r_steps <= '0;
            else if (r_state == S_J4 && ok_jump) r_steps <= r_steps + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_num  <= r_p;
            r_o_den  <= r_q;
            r_o_stat <= r_stat;
        end
        case (r_state)
            S_IDLE: begin
                r_x    <= i_x_value;
                r_stat <= (i_x_value == '0) ? STAT_ZERO : STAT_OK;
                r_ln   <= VAL_W'(i_x_value >> FRAC_BITS);
                r_rn   <= VAL_W'(i_x_value >> FRAC_BITS) + 1'b1;
                r_ld   <= VAL_W'(1);
                r_rd   <= VAL_W'(1);
                if (i_x_value == '0) begin
                    r_p <= '0;
                    r_q <= '0;
                end else begin
                    r_p <= VAL_W'((33'(i_x_value) + (33'(1) << (FRAC_BITS-1))) >> FRAC_BITS);
                    r_q <= VAL_W'(1);
                end
            end
            S_SDIVW: begin
                r_p <= VAL_W'(1);
                r_q <= div_res.quo[VAL_W-1:0];
            end
            S_MT: r_xq <= prod;
            S_CHK: begin
                if (!below && !above) r_stat <= STAT_OK;
                else if (r_steps >= SW'(MAX_STEPS)) r_stat <= STAT_CAP;
                r_below <= below;
                r_eneg  <= ediff[65];
                r_e     <= ediff[65] ? 64'(-ediff) : ediff[63:0];
                if (below) begin
                    r_ln <= r_p;
                    r_ld <= r_q;
                end else begin
                    r_rn <= r_p;
                    r_rd <= r_q;
                end
            end
            S_U1, S_V1: r_te <= WIDE_W'(prod);
            S_U2, S_V2: r_te <= r_te + (WIDE_W'(prod) << 32);
            S_U3, S_V3: begin
                r_ts <= WIDE_W'(prod) << FRAC_BITS;
                if (r_eneg) r_te <= -r_te;
            end
            S_U4: r_u <= r_te - r_ts;
            S_V4: r_v <= r_ts - r_te;
            S_DSET: begin
                // Zero numerator counts as non-negative for the floor rounding.
                r_kdiff <= (dnum != '0) && (dnum[WIDE_W-1] != dden[WIDE_W-1]);
                r_kmag  <= '0;
                r_kneg  <= 1'b0;
            end
            S_K: begin
                r_kmag <= kcap + KQ_W'(r_kdiff && !div_res.rem_zero);
                r_kneg <= r_kdiff;
            end
            S_J1: r_j <= 65'(prod) + jhi1;
            S_J2: begin
                r_n1 <= r_kneg ? 67'(base1) - 67'(r_j) : 67'(base1) + 67'(r_j);
                r_j  <= 65'(prod) + jhi2;
            end
            S_J3: r_n2 <= r_kneg ? 67'(base2) - 67'(r_j) : 67'(base2) + 67'(r_j);
            S_J4: begin
                if (ok_jump) begin
                    r_ln <= nln;
                    r_ld <= nld;
                    r_rn <= nrn;
                    r_rd <= nrd;
                    r_p  <= np[VAL_W-1:0];
                    r_q  <= nq[VAL_W-1:0];
                end else begin
                    r_stat <= STAT_OVF;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid   = r_o_valid;
    assign o_numerator   = r_o_num;
    assign o_denominator = r_o_den;
    assign o_status      = r_o_stat;

    `RFA_ASSERT_NOW(a_zero_word, i_clk, i_rst_n, o_out_valid && (o_status == STAT_ZERO), (o_numerator == '0) && (o_denominator == '0))
    `RFA_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_acc, o_in_stall)
    `RFA_ASSERT_NOW(a_step_bound, i_clk, i_rst_n, 1'b1, r_steps <= SW'(MAX_STEPS))

endmodule
`default_nettype wire

// ----- sim/tb.sv -----
// Self-checking testbench of rational_fraction_approximator_unit: feeds Q16.16 words under
// several tolerance settings and compares every fraction with a built-in predictor.
// Depends on rfa_pkg and the RTL of the approximator.
module tb;
    import rfa_pkg::*;

    typedef struct packed {
        logic [30:0] num;
        logic [30:0] den;
        logic [1:0]  status;
    } frac_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [31:0] x_word = '0;
    logic        out_stall = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [31:0] cfg_word = '0;
    wire         o_in_stall, o_out_valid, o_cfg_ready;
    wire  [30:0] o_numerator, o_denominator;
    wire  [1:0]  o_status;

    rational_fraction_approximator_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(o_in_stall), .i_x_value(x_word),
        .o_out_valid(o_out_valid), .i_out_stall(out_stall),
        .o_numerator(o_numerator), .o_denominator(o_denominator), .o_status(o_status),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(cfg_word)
    );

    always #5 i_clk = ~i_clk;

    logic [31:0] x_pending[$];
    frac_t       fraction_due[$];
    logic [31:0] tol_model = 32'd655;
    logic [31:0] corner_x [14] = '{32'd0, 32'd1, 32'd655, 32'd656, 32'hFFFF_FFFF,
                                   32'h0001_0000, 32'h0001_8000, 32'h0000_7FFF,
                                   32'h7FFF_8000, 32'h8000_0000, 32'hFFFF_8000,
                                   32'h0003_243F, 32'h0000_5555, 32'hAAAA_AAAA};
    bit          calm = 0;
    bit          x_taken = 0;
    int          in_gap = 0;
    int          stall_left = 0;
    int          mismatches = 0;
    longint      cycles = 0;
    longint      cycle_budget = 100000;

    function automatic longint floor_quot(logic signed [129:0] a, logic signed [129:0] b);
        logic [129:0] am, bm, qm, rm;
        longint mag;
        if (b == 0) return 0;
        am = (a < 0) ? -a : a;
        bm = (b < 0) ? -b : b;
        qm = am / bm;
        rm = am % bm;
        mag = (qm > 130'h1_0000_0000) ? 64'h1_0000_0000 : longint'(qm);
        if (a != 0 && ((a < 0) != (b < 0))) return -(mag + ((rm != 0) ? 1 : 0));
        return mag;
    endfunction

    function automatic bit fits31(longint v);
        return v >= 0 && v <= 64'h7FFF_FFFF;
    endfunction

    function automatic void approximate_fraction(input logic [31:0] x, input logic [31:0] tol,
                                                 output frac_t r, output int steps);
        longint ln, ld, rn, rd, p, q, nln, nld, nrn, nrd, k;
        logic signed [129:0] xs, ts, ps, qs, e, u, v, sc;
        bit below, above;
        steps = 0;
        r.status = STAT_OK;
        if (x == 0) begin
            r.num = '0; r.den = '0; r.status = STAT_ZERO;
            return;
        end
        if (x <= tol) begin
            r.num = 31'd1;
            r.den = 31'((64'd1 << FRAC_BITS) / tol);
            return;
        end
        sc = 130'sd1 <<< FRAC_BITS;
        xs = x;
        ts = tol;
        ln = x >> FRAC_BITS; ld = 1;
        p = (64'(x) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS; q = 1;
        rn = ln + 1; rd = 1;
        forever begin
            ps = p * sc;
            qs = q;
            below = ps + ts * qs < xs * qs;
            above = ps > xs * qs + ts * qs;
            if (!below && !above) break;
            if (steps >= 1000) begin
                r.status = STAT_CAP;
                break;
            end
            e = 2 * xs * qs - ps;
            nln = ln; nld = ld; nrn = rn; nrd = rd;
            if (below) begin
                nln = p; nld = q;
            end else begin
                nrn = p; nrd = q;
            end
            u = nld * e - nln * qs * sc;
            v = nrn * qs * sc - nrd * e;
            if (below) begin
                k = floor_quot(v, u);
                nrn = nrn + k * nln;
                nrd = nrd + k * nld;
            end else begin
                k = floor_quot(u, v);
                nln = nln + k * nrn;
                nld = nld + k * nrd;
            end
            if (!fits31(nln) || !fits31(nld) || !fits31(nrn) || !fits31(nrd) ||
                !fits31(nln + nrn) || !fits31(nld + nrd)) begin
                r.status = STAT_OVF;
                break;
            end
            ln = nln; ld = nld; rn = nrn; rd = nrd;
            p = nln + nrn; q = nld + nrd;
            steps++;
        end
        r.num = p[30:0];
        r.den = q[30:0];
    endfunction

    // Acceptance is decided on the values seen just before the rising edge.
    always @(posedge i_clk) begin
        frac_t want, got;
        int steps;
        cycles++;
        x_taken = i_rst_n && in_valid && !o_in_stall;
        if (x_taken) begin
            approximate_fraction(x_word, tol_model, want, steps);
            fraction_due.push_back(want);
            cycle_budget += 3 * ((steps + 1) * 130 + 300);
        end
        if (i_rst_n && o_out_valid && !out_stall) begin
            got = '{o_numerator, o_denominator, o_status};
            if (fraction_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word: num %0d den %0d status %0d",
                                               got.num, got.den, got.status);
            end else begin
                want = fraction_due.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d/%0d st %0d, got %0d/%0d st %0d",
                                 want.num, want.den, want.status,
                                 got.num, got.den, got.status);
                end
            end
        end
        if (cycles > cycle_budget) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (in_valid && !x_taken) begin
            in_valid <= 1'b1;
        end else if (in_gap > 0) begin
            in_valid <= 1'b0;
            in_gap--;
        end else if (x_pending.size() > 0 && !calm && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            in_gap = $urandom_range(0, 8);
        end else if (x_pending.size() > 0) begin
            in_valid <= 1'b1;
            x_word <= x_pending.pop_front();
        end else begin
            in_valid <= 1'b0;
        end

        if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left--;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            out_stall <= 1'b1;
            stall_left = $urandom_range(0, 8);
        end else begin
            out_stall <= 1'b0;
        end
    end

    function automatic logic [31:0] random_x();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom >> $urandom_range(0, 31);
            2: return ($urandom_range(1, 200) << FRAC_BITS) | ($urandom & 32'hFFFF);
            default: return $urandom_range(1, 32'h0004_0000);
        endcase
    endfunction

    // Checked at the rising edge, where the driven inputs are settled.
    task automatic drain();
        do @(posedge i_clk);
        while (x_pending.size() != 0 || in_valid || fraction_due.size() != 0);
        repeat (5) @(negedge i_clk);
    endtask

    task automatic set_tolerance(logic [31:0] value);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_word <= value;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        tol_model = value;
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(logic [31:0] tol, int count);
        set_tolerance(tol);
        repeat (count) x_pending.push_back(random_x());
        drain();
    endtask

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset tolerance first: zero, at and just above tolerance, both ends of the range.
        foreach (corner_x[i])
            x_pending.push_back(corner_x[i]);
        repeat (400) x_pending.push_back(random_x());
        drain();

        run_phase(32'd1, 250);
        // A tolerance above one makes the small-x denominator zero.
        run_phase(32'hFFFF_FFFF, 30);
        run_phase(32'h0001_0000, 200);
        run_phase($urandom_range(1, 32'h0010_0000), 300);
        run_phase($urandom | 32'd1, 100);
        calm = 1;
        run_phase(32'd3, 150);

        repeat (200) @(negedge i_clk);
        if (mismatches == 0 && fraction_due.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule
